### hw/rtl/nbg_pkg.sv
// Shared types and constants for the n-body gravity acceleration block.
`timescale 1ns / 1ps
package nbg_pkg;

    localparam int POS_W   = 48;
    localparam int GM_W    = 64;
    localparam int ACC_W   = 64;
    localparam int SEP_W   = 49;   // signed separation
    localparam int MAG_W   = 49;   // separation magnitude
    localparam int SQ_W    = 97;   // one squared component
    localparam int SUM_W   = 98;   // squared distance
    localparam int ROOT_W  = 49;
    localparam int DEN_W   = 147;
    localparam int NUM_W   = 113;
    localparam int ACC_SHIFT = 74;
    localparam int MUL_A_W = 98;
    localparam int MUL_B_W = 64;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int WORD_W  = 2 * POS_W + GM_W;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUN_GM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd1;

    localparam logic [63:0] SUN_GM_RESET = 64'd5460494900000000;
    localparam logic [4:0]  ACTIVE_RESET = 5'd9;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [3:0]         body_index;
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic [63:0]        body_gm;
    } t_in;

    typedef struct packed {
        logic [3:0]         result_index;
        logic signed [63:0] accel_x;
        logic signed [63:0] accel_y;
        logic               saturated;
        logic               last;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RDI, ST_LDI, ST_KICK, ST_WAIT, ST_NEXTJ, ST_RDJ, ST_LDJ, ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        SP_SQX, SP_SQY, SP_ROOT, SP_DEN, SP_NUMX, SP_DIVX, SP_NUMY, SP_DIVY
    } t_step;

endpackage

### hw/rtl/nbg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module nbg_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hw/rtl/nbg_mul.sv
// Iterative multiplier: one 8-bit digit of the B operand per cycle, MSB first.
`timescale 1ns / 1ps
module nbg_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nbg_pkg::MUL_A_W-1:0] i_a,
    input  logic [nbg_pkg::MUL_B_W-1:0] i_b,
    output logic                        o_done,
    output logic [nbg_pkg::MUL_P_W-1:0] o_p
);
    logic [nbg_pkg::MUL_A_W-1:0] r_a;
    logic [nbg_pkg::MUL_B_W-1:0] r_b;
    logic [nbg_pkg::MUL_P_W-1:0] r_p;
    logic [2:0]                  r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [nbg_pkg::MUL_A_W+7:0] n_part;

    assign n_part = r_a * r_b[nbg_pkg::MUL_B_W-1 -: 8];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift-and-add datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            r_p <= {r_p[nbg_pkg::MUL_P_W-9:0], 8'd0}
                   + {{(nbg_pkg::MUL_P_W-nbg_pkg::MUL_A_W-8){1'b0}}, n_part};
            r_b <= {r_b[nbg_pkg::MUL_B_W-9:0], 8'd0};
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule

### hw/rtl/nbg_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module nbg_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [nbg_pkg::SUM_W-1:0]  i_s,
    output logic                       o_done,
    output logic [nbg_pkg::ROOT_W-1:0] o_root
);
    logic [nbg_pkg::SUM_W-1:0]  r_s;
    logic [51:0]                r_rem;
    logic [nbg_pkg::ROOT_W-1:0] r_root;
    logic [5:0]                 r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [51:0]                n_sh;
    logic [51:0]                n_trial;
    logic                       n_ge;

    assign n_sh    = {r_rem[49:0], r_s[nbg_pkg::SUM_W-1 -: 2]};
    assign n_trial = {1'b0, r_root, 2'b01};
    assign n_ge    = (n_sh >= n_trial);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(nbg_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one root bit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_s    <= i_s;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_s    <= {r_s[nbg_pkg::SUM_W-3:0], 2'b00};
            r_rem  <= n_ge ? (n_sh - n_trial) : n_sh;
            r_root <= {r_root[nbg_pkg::ROOT_W-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

### hw/rtl/nbg_div.sv
// Restoring divider: floor(num*2^74/den), clipped to 2^63-1 with a flag.
`timescale 1ns / 1ps
module nbg_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [nbg_pkg::NUM_W-1:0] i_num,
    input  logic [nbg_pkg::DEN_W-1:0] i_den,
    output logic                      o_done,
    output logic [63:0]               o_q,
    output logic                      o_sat
);
    localparam int RW = nbg_pkg::NUM_W + nbg_pkg::ACC_SHIFT;   // 187
    localparam int DW = nbg_pkg::DEN_W + 63;                  // 210

    logic [RW-1:0] r_rem;
    logic [DW-1:0] r_d;
    logic [62:0]   r_q;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic          r_sat;
    logic          n_ge;

    assign n_ge = ({{(DW-RW){1'b0}}, r_rem} >= r_d);

    // control: step 0 is the overflow test, then 63 quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_sat  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_sat  <= 1'b0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd0 && n_ge) begin
                    r_sat  <= 1'b1;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift-subtract datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {i_num, {nbg_pkg::ACC_SHIFT{1'b0}}};
            r_d   <= {i_den, 63'd0};
            r_q   <= '0;
        end else if (r_busy) begin
            r_d <= {1'b0, r_d[DW-1:1]};
            if (r_cnt != 6'd0) begin
                if (n_ge) begin
                    r_rem <= r_rem - r_d[RW-1:0];
                end
                r_q <= {r_q[61:0], n_ge};
            end
        end
    end

    assign o_done = r_done;
    assign o_sat  = r_sat;
    assign o_q    = r_sat ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, r_q};
endmodule

### hw/rtl/nbody_gravity_accel.sv
// Top level: 2D n-body gravity acceleration with a central sun, body table in RAM.
// A load beat writes one body word into the table. A compute beat emits one result
// per active body; each nonzero pull term takes five multiplies, a square root,
// two divides and the table read and loop control steps; busy is high while a
// compute runs. Results are strobed for one cycle and cannot be stalled. Reset
// is synchronous: control and config registers return to their defaults; the
// body table holds nothing until loaded.
`timescale 1ns / 1ps
module nbody_gravity_accel #(
    parameter int MAX_BODIES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  nbg_pkg::t_in                    i_item,
    output logic                            busy,
    output logic                            o_result_valid,
    output nbg_pkg::t_out                   o_result,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [nbg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [63:0]                     i_cfg_data
);
    localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int CW = AW + 1;
    localparam int PW = nbg_pkg::POS_W;

    nbg_pkg::t_state r_state, n_state;
    nbg_pkg::t_step  r_step, n_step;

    logic [63:0]   r_sun_gm;
    logic [4:0]    r_active;
    logic [CW-1:0] r_n, r_i, r_j;
    logic          r_sun;
    logic signed [PW-1:0] r_xi, r_yi;
    logic [nbg_pkg::MAG_W-1:0]  r_magx, r_magy;
    logic          r_negx, r_negy;
    logic [63:0]   r_gm;
    logic [nbg_pkg::SQ_W-1:0]   r_sqx;
    logic [nbg_pkg::SUM_W-1:0]  r_s;
    logic [nbg_pkg::ROOT_W-1:0] r_root;
    logic [nbg_pkg::DEN_W-1:0]  r_den;
    logic [nbg_pkg::NUM_W-1:0]  r_num;
    logic signed [63:0] r_ax, r_ay;
    logic          r_sat;
    logic          r_res_valid;
    nbg_pkg::t_out r_out;

    // RAM and unit hookup
    logic                           ram_we;
    logic [AW-1:0]                  ram_raddr;
    logic [nbg_pkg::WORD_W-1:0]     ram_rdata;
    logic                           mul_start, sqrt_start, div_start;
    logic                           mul_done, sqrt_done, div_done;
    logic [nbg_pkg::MUL_A_W-1:0]    mul_a;
    logic [nbg_pkg::MUL_B_W-1:0]    mul_b;
    logic [nbg_pkg::MUL_P_W-1:0]    mul_p;
    logic [nbg_pkg::ROOT_W-1:0]     sqrt_root;
    logic [63:0]                    div_q;
    logic                           div_sat;

    // combinational helpers
    logic [4:0]    n_n16;
    logic [CW-1:0] n_ncalc, n_base, n_cand;
    logic          unit_done;
    logic [nbg_pkg::SUM_W-1:0] n_sum;
    logic signed [PW-1:0] rd_x, rd_y;
    logic signed [nbg_pkg::SEP_W-1:0] n_dx, n_dy;
    logic [64:0]   n_addx, n_addy;
    logic signed [63:0] n_term;

    function automatic logic [64:0] f_sat_add(input logic signed [63:0] acc,
                                              input logic signed [63:0] t);
        logic signed [64:0] s;
        s = {acc[63], acc} + {t[63], t};
        if (s[64] != s[63]) begin
            return {1'b1, s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF};
        end
        return {1'b0, s[63:0]};
    endfunction

    function automatic logic [nbg_pkg::MAG_W-1:0] f_abs(
            input logic signed [nbg_pkg::SEP_W-1:0] d);
        return d[nbg_pkg::SEP_W-1] ? nbg_pkg::MAG_W'(-d) : nbg_pkg::MAG_W'(d);
    endfunction

    assign n_n16   = (r_active > 5'd16) ? 5'd16 : r_active;
    assign n_ncalc = (int'(n_n16) > MAX_BODIES) ? CW'(MAX_BODIES) : CW'(n_n16);
    assign n_base  = r_sun ? '0 : r_j + 1'b1;
    assign n_cand  = (n_base == r_i) ? n_base + 1'b1 : n_base;
    assign unit_done = mul_done | sqrt_done | div_done;
    assign n_sum   = {1'b0, r_sqx} + mul_p[nbg_pkg::SUM_W-1:0];

    // body word: x, y, gm
    assign rd_x = ram_rdata[nbg_pkg::WORD_W-1 -: PW];
    assign rd_y = ram_rdata[nbg_pkg::WORD_W-PW-1 -: PW];
    assign n_dx = (r_state == nbg_pkg::ST_LDI) ? nbg_pkg::SEP_W'(rd_x)
                : nbg_pkg::SEP_W'(r_xi) - nbg_pkg::SEP_W'(rd_x);
    assign n_dy = (r_state == nbg_pkg::ST_LDI) ? nbg_pkg::SEP_W'(rd_y)
                : nbg_pkg::SEP_W'(r_yi) - nbg_pkg::SEP_W'(rd_y);

    // term sign is opposite to the separation
    assign n_term = (r_step == nbg_pkg::SP_DIVX)
                  ? (r_negx ? div_q : -div_q)
                  : (r_negy ? div_q : -div_q);
    assign n_addx = f_sat_add(r_ax, n_term);
    assign n_addy = f_sat_add(r_ay, n_term);

    assign ram_we = (r_state == nbg_pkg::ST_IDLE) && start
                 && (i_item.kind == nbg_pkg::KIND_LOAD)
                 && (int'(i_item.body_index) < MAX_BODIES);

    nbg_ram #(.WIDTH(nbg_pkg::WORD_W), .DEPTH(MAX_BODIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_item.body_index)),
        .i_wdata ({i_item.pos_x, i_item.pos_y, i_item.body_gm}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_step)
            nbg_pkg::SP_SQX: begin
                mul_a = nbg_pkg::MUL_A_W'(r_magx);
                mul_b = nbg_pkg::MUL_B_W'(r_magx);
            end
            nbg_pkg::SP_SQY: begin
                mul_a = nbg_pkg::MUL_A_W'(r_magy);
                mul_b = nbg_pkg::MUL_B_W'(r_magy);
            end
            nbg_pkg::SP_DEN: begin
                mul_a = r_s;
                mul_b = nbg_pkg::MUL_B_W'(r_root);
            end
            nbg_pkg::SP_NUMX: begin
                mul_a = nbg_pkg::MUL_A_W'(r_magx);
                mul_b = r_gm;
            end
            nbg_pkg::SP_NUMY: begin
                mul_a = nbg_pkg::MUL_A_W'(r_magy);
                mul_b = r_gm;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    nbg_mul u_mul (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (mul_start),
        .i_a (mul_a), .i_b (mul_b), .o_done (mul_done), .o_p (mul_p)
    );

    nbg_sqrt u_sqrt (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (sqrt_start),
        .i_s (r_s), .o_done (sqrt_done), .o_root (sqrt_root)
    );

    nbg_div u_div (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (div_start),
        .i_num (r_num), .i_den (r_den), .o_done (div_done), .o_q (div_q), .o_sat (div_sat)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nbg_pkg::ST_IDLE;
            r_step  <= nbg_pkg::SP_SQX;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // next state and unit kicks
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        ram_raddr  = r_i[AW-1:0];
        case (r_state)
            nbg_pkg::ST_IDLE: begin
                if (start && i_item.kind == nbg_pkg::KIND_COMPUTE && n_ncalc != '0) begin
                    n_state = nbg_pkg::ST_RDI;
                end
            end
            nbg_pkg::ST_RDI: begin
                n_state = nbg_pkg::ST_LDI;
            end
            nbg_pkg::ST_LDI, nbg_pkg::ST_LDJ: begin
                n_step  = nbg_pkg::SP_SQX;
                n_state = nbg_pkg::ST_KICK;
            end
            nbg_pkg::ST_KICK: begin
                case (r_step)
                    nbg_pkg::SP_ROOT:                  sqrt_start = 1'b1;
                    nbg_pkg::SP_DIVX, nbg_pkg::SP_DIVY: div_start  = 1'b1;
                    default:                           mul_start  = 1'b1;
                endcase
                n_state = nbg_pkg::ST_WAIT;
            end
            nbg_pkg::ST_WAIT: begin
                if (unit_done) begin
                    n_state = nbg_pkg::ST_KICK;
                    case (r_step)
                        nbg_pkg::SP_SQX:  n_step = nbg_pkg::SP_SQY;
                        nbg_pkg::SP_SQY: begin
                            if (n_sum == '0) begin
                                n_state = nbg_pkg::ST_NEXTJ;
                            end else begin
                                n_step = nbg_pkg::SP_ROOT;
                            end
                        end
                        nbg_pkg::SP_ROOT: n_step = nbg_pkg::SP_DEN;
                        nbg_pkg::SP_DEN:  n_step = nbg_pkg::SP_NUMX;
                        nbg_pkg::SP_NUMX: n_step = nbg_pkg::SP_DIVX;
                        nbg_pkg::SP_DIVX: n_step = nbg_pkg::SP_NUMY;
                        nbg_pkg::SP_NUMY: n_step = nbg_pkg::SP_DIVY;
                        default:          n_state = nbg_pkg::ST_NEXTJ;
                    endcase
                end
            end
            nbg_pkg::ST_NEXTJ: begin
                n_state = (n_cand >= r_n) ? nbg_pkg::ST_EMIT : nbg_pkg::ST_RDJ;
            end
            nbg_pkg::ST_RDJ: begin
                ram_raddr = r_j[AW-1:0];
                n_state   = nbg_pkg::ST_LDJ;
            end
            nbg_pkg::ST_EMIT: begin
                n_state = (r_i == r_n - 1'b1) ? nbg_pkg::ST_IDLE : nbg_pkg::ST_RDI;
            end
            default: n_state = nbg_pkg::ST_IDLE;
        endcase
    end

    // config and loop control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sun_gm    <= nbg_pkg::SUN_GM_RESET;
            r_active    <= nbg_pkg::ACTIVE_RESET;
            r_n         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_sun       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= (r_state == nbg_pkg::ST_EMIT);
            if (i_cfg_valid) begin
                if (i_cfg_index == nbg_pkg::CFG_SUN_GM) begin
                    r_sun_gm <= i_cfg_data;
                end else if (i_cfg_index == nbg_pkg::CFG_ACTIVE) begin
                    r_active <= i_cfg_data[4:0];
                end
            end
            if (r_state == nbg_pkg::ST_IDLE && start) begin
                r_n <= n_ncalc;
                r_i <= '0;
            end
            if (r_state == nbg_pkg::ST_LDI) begin
                r_sun <= 1'b1;
            end
            if (r_state == nbg_pkg::ST_LDJ) begin
                r_sun <= 1'b0;
            end
            if (r_state == nbg_pkg::ST_NEXTJ) begin
                r_j <= n_cand;
            end
            if (r_state == nbg_pkg::ST_EMIT) begin
                r_i <= r_i + 1'b1;
            end
        end
    end

    // term datapath
    always_ff @(posedge i_clk) begin
        if (r_state == nbg_pkg::ST_LDI || r_state == nbg_pkg::ST_LDJ) begin
            r_magx <= f_abs(n_dx);
            r_magy <= f_abs(n_dy);
            r_negx <= n_dx[nbg_pkg::SEP_W-1];
            r_negy <= n_dy[nbg_pkg::SEP_W-1];
        end
        if (r_state == nbg_pkg::ST_LDI) begin
            r_xi <= rd_x;
            r_yi <= rd_y;
            r_gm <= r_sun_gm;
            r_ax <= '0;
            r_ay <= '0;
            r_sat <= 1'b0;
        end
        if (r_state == nbg_pkg::ST_LDJ) begin
            r_gm <= ram_rdata[nbg_pkg::GM_W-1:0];
        end
        if (r_state == nbg_pkg::ST_WAIT && unit_done) begin
            case (r_step)
                nbg_pkg::SP_SQX:  r_sqx  <= mul_p[nbg_pkg::SQ_W-1:0];
                nbg_pkg::SP_SQY:  r_s    <= n_sum;
                nbg_pkg::SP_ROOT: r_root <= sqrt_root;
                nbg_pkg::SP_DEN:  r_den  <= mul_p[nbg_pkg::DEN_W-1:0];
                nbg_pkg::SP_NUMX, nbg_pkg::SP_NUMY: r_num <= mul_p[nbg_pkg::NUM_W-1:0];
                nbg_pkg::SP_DIVX: begin
                    r_ax  <= n_addx[63:0];
                    r_sat <= r_sat | div_sat | n_addx[64];
                end
                default: begin
                    r_ay  <= n_addy[63:0];
                    r_sat <= r_sat | div_sat | n_addy[64];
                end
            endcase
        end
        if (r_state == nbg_pkg::ST_EMIT) begin
            r_out.result_index <= 4'(r_i);
            r_out.accel_x      <= r_ax;
            r_out.accel_y      <= r_ay;
            r_out.saturated    <= r_sat;
            r_out.last         <= (r_i == r_n - 1'b1);
        end
    end

    assign busy           = (r_state != nbg_pkg::ST_IDLE);
    assign o_result_valid = r_res_valid;
    assign o_result       = r_out;
    assign o_cfg_ready    = 1'b1;
endmodule
